// ----- hw/rtl/gsns_pkg.sv -----
// Shared types and constants of the grid step note sequencer.
// Used by gsns_div, gsns_grid and grid_step_note_sequencer; depends on nothing.
package gsns_pkg;

	localparam int NOTES       = 128;
	localparam int MAX_RESULTS = 32;
	localparam int CNT_W       = 6;
	localparam int FC_W        = 48;
	localparam int FPS_W       = 24;
	localparam int LEN_W       = 5;
	localparam int NOTE_W      = 7;
	localparam int SAMPLE_W    = 16;
	localparam int FRAME_W     = 16;
	localparam int CELL_W      = 4;
	localparam int STEP_W      = 4;
	localparam int DIV_CNT_W   = $clog2(FC_W);

	// Sounding flags are kept eight notes to a memory word.
	localparam int SND_BITS  = 8;
	localparam int SND_WORDS = NOTES / SND_BITS;
	localparam int SND_AW    = $clog2(SND_WORDS);
	localparam int SND_BW    = $clog2(SND_BITS);

	localparam logic [NOTE_W-1:0] VEL_ON  = 7'd100;
	localparam logic [NOTE_W-1:0] VEL_OFF = 7'd0;

	// Configuration register indexes and reset values
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_FRAMES_PER_STEP = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEQUENCE_LENGTH = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_BASE_NOTE       = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_PLAYING         = 2'd3;

	localparam logic [FPS_W-1:0]  FPS_RESET  = 24'd6000;
	localparam logic [LEN_W-1:0]  LEN_RESET  = 5'd16;
	localparam logic [NOTE_W-1:0] BASE_RESET = 7'd60;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DIV_OLD,
		ST_DIV_NEW,
		ST_DIV_MOD,
		ST_OFF_RD,
		ST_OFF_LD,
		ST_OFF_EMIT,
		ST_ON_RD,
		ST_ON_LD,
		ST_ON_EMIT,
		ST_FLUSH
	} state_t;

	typedef struct packed {
		logic             start;
		logic [FC_W-1:0]  num;
		logic [FPS_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [FC_W-1:0]  quot;
		logic [FPS_W-1:0] rem;
	} div_rsp_t;

	typedef struct packed {
		logic              en;
		logic [CELL_W-1:0] col;
		logic [CELL_W-1:0] row;
		logic              on;
	} grid_wr_t;

	typedef struct packed {
		logic              on;
		logic [NOTE_W-1:0] note;
	} note_ev_t;

endpackage

// ----- hw/rtl/gsns_div.sv -----
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on gsns_pkg for widths and the request/response structs.
module gsns_div import gsns_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  div_req_t req,
	output div_rsp_t rsp
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [FC_W-1:0]      num_q;
	logic [FPS_W-1:0]     den_q;
	logic [FPS_W-1:0]     rem_q;

	logic [FPS_W:0] trial;
	logic [FPS_W:0] diff;
	logic           ge;

	always_comb begin
		trial = {rem_q, num_q[FC_W-1]};
		ge    = trial >= {1'b0, den_q};
		diff  = trial - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CNT_W'(FC_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// Dividend shifts out at the top while quotient bits shift in at the bottom.
	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			den_q <= req.den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[FPS_W-1:0] : trial[FPS_W-1:0];
			num_q <= {num_q[FC_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;
	assign rsp.rem  = rem_q;

`ifndef NO_ASSERTIONS
	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q)
		else $error("divider restarted while busy");

	a_done_after_run: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> $past(busy_q) && !busy_q)
		else $error("divider done without a run");
`endif

endmodule

// ----- hw/rtl/gsns_grid.sv -----
// Cell grid memory: one word of row bits per column, bit-masked write, registered read.
// Depends on gsns_pkg for the write struct; per-column valid bits stand in for a clear.
module gsns_grid import gsns_pkg::*; #(
	parameter int ROWS    = 16,
	parameter int COLUMNS = 16,
	localparam int AW     = (COLUMNS > 1) ? $clog2(COLUMNS) : 1,
	localparam int RW     = (ROWS > 1) ? $clog2(ROWS) : 1
) (
	input  logic            clk,
	input  logic            arst_n,
	input  grid_wr_t        wr,
	input  logic            rd_en,
	input  logic [AW-1:0]   rd_col,
	output logic [ROWS-1:0] rd_data
);

	logic [ROWS-1:0]    grid_mem_q [COLUMNS];
	logic [COLUMNS-1:0] vld_q;
	logic [ROWS-1:0]    rd_word_q;
	logic               rd_vld_q;

	logic          wr_ok;
	logic [AW-1:0] col_idx;
	logic [RW-1:0] row_idx;

	always_comb begin
		wr_ok   = wr.en && (32'(wr.col) < COLUMNS) && (32'(wr.row) < ROWS);
		col_idx = AW'(wr.col);
		row_idx = RW'(wr.row);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_ok) begin
			vld_q[col_idx] <= 1'b1;
		end
	end

	// A column never written reads as all cells cleared.
	always_ff @(posedge clk) begin
		if (wr_ok) begin
			if (!vld_q[col_idx]) begin
				grid_mem_q[col_idx] <= wr.on ? (ROWS'(1) << row_idx) : '0;
			end else begin
				grid_mem_q[col_idx][row_idx] <= wr.on;
			end
		end
		if (rd_en) begin
			rd_word_q <= grid_mem_q[rd_col];
			rd_vld_q  <= vld_q[rd_col];
		end
	end

	assign rd_data = rd_vld_q ? rd_word_q : '0;

endmodule

// ----- hw/rtl/grid_step_note_sequencer.sv -----
// Top level of the grid step note sequencer: control sequencer, sounding-note memory,
// configuration registers and result register. Depends on gsns_pkg, gsns_div, gsns_grid.
//
// Channel   Direction  Handshake                    Payload
// command   in         start & !busy                action, sample_count, frame_stamp,
//                                                   cell_column, cell_row, cell_on
// config    in         cfg_valid & cfg_ready        cfg_index, cfg_data
// result    out        result_strobe (one cycle)    note_on, note, velocity, event_frame,
//                                                   step_column, last
//
// Work per command: a cell write or a tick while stopped leaves the block idle. A tick
// that keeps the step makes two runs of the shared bit-serial divider; a tick that
// changes the step makes three divider runs, a sweep of the 16-word sounding memory
// (read, load, emit per word), then the note-ons of the new column and a flush.
// Reset clears the counter, column and the memories' valid bits, and sets the configuration to its reset values.
// The receiver cannot stall: each result shows for exactly one cycle.
module grid_step_note_sequencer import gsns_pkg::*; #(
	parameter int ROWS    = 16,
	parameter int COLUMNS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 action,
	input  logic [SAMPLE_W-1:0]  sample_count,
	input  logic [FRAME_W-1:0]   frame_stamp,
	input  logic [CELL_W-1:0]    cell_column,
	input  logic [CELL_W-1:0]    cell_row,
	input  logic                 cell_on,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FPS_W-1:0]     cfg_data,
	output logic                 result_strobe,
	output logic                 note_on,
	output logic [NOTE_W-1:0]    note,
	output logic [NOTE_W-1:0]    velocity,
	output logic [FRAME_W-1:0]   event_frame,
	output logic [STEP_W-1:0]    step_column,
	output logic                 last
);

	localparam int AW = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
	localparam int RW = (ROWS > 1) ? $clog2(ROWS) : 1;

	// Configuration registers
	logic [FPS_W-1:0]  fps_q;
	logic [LEN_W-1:0]  seq_len_q;
	logic [NOTE_W-1:0] base_q;
	logic              playing_q;

	// Sequencer state
	state_t           state_q, state_d;
	logic [FC_W-1:0]  fc_q;
	logic [FC_W-1:0]  oldq_q;
	logic [AW-1:0]    column_q;
	logic [FRAME_W-1:0] frame_q;
	logic [SND_AW-1:0]  word_q;
	logic [SND_BITS-1:0] bits_q;
	logic [ROWS-1:0]  rowbits_q;
	logic [CNT_W-1:0] cnt_q;
	note_ev_t         pend_q;
	logic             pend_v_q;
	logic [SND_BITS-1:0] acc_q;
	logic [SND_AW-1:0]   acc_word_q;
	logic                acc_any_q;

	// Result register
	logic               result_strobe_q;
	logic               note_on_q;
	logic [NOTE_W-1:0]  note_q;
	logic [NOTE_W-1:0]  velocity_q;
	logic [FRAME_W-1:0] event_frame_q;
	logic [STEP_W-1:0]  step_column_q;
	logic               last_q;

	// Sounding-note memory
	logic [SND_BITS-1:0] snd_mem_q [SND_WORDS];
	logic [SND_WORDS-1:0] snd_vld_q;
	logic [SND_BITS-1:0] snd_rword_q;
	logic                snd_rvld_q;
	logic [SND_BITS-1:0] snd_rdata;
	logic                snd_re;
	logic                snd_we;
	logic [SND_AW-1:0]   snd_waddr;
	logic [SND_BITS-1:0] snd_wdata;

	// Control and datapath signals
	logic              accept;
	logic [FPS_W-1:0]  fps_eff;
	logic [LEN_W-1:0]  len_eff;
	div_req_t          div_req;
	div_rsp_t          div_rsp;
	grid_wr_t          grid_wr;
	logic              grid_re;
	logic [ROWS-1:0]   grid_rdata;
	logic [SND_BW-1:0] off_bit;
	logic [RW-1:0]     row_idx;
	logic [NOTE_W:0]   note_sum;
	logic              note_ok;
	logic              room;
	logic [SND_BITS-1:0] acc_new;
	logic              emit;
	note_ev_t          emit_ev;
	logic              fire;
	logic              fire_last;

	assign busy      = (state_q != ST_IDLE);
	assign accept    = start && !busy;
	assign cfg_ready = 1'b1;

	// Zero frames per step counts as one; sequence length clamps to one..COLUMNS.
	always_comb begin
		fps_eff = (fps_q == '0) ? FPS_W'(1) : fps_q;
		if (seq_len_q == '0) begin
			len_eff = LEN_W'(1);
		end else if (32'(seq_len_q) > COLUMNS) begin
			len_eff = LEN_W'(COLUMNS);
		end else begin
			len_eff = seq_len_q;
		end
	end

	// Lowest sounding note in the held word, lowest set cell of the held column.
	always_comb begin
		off_bit = '0;
		for (int i = SND_BITS - 1; i >= 0; i--) begin
			if (bits_q[i]) off_bit = SND_BW'(i);
		end
		row_idx = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (rowbits_q[i]) row_idx = RW'(i);
		end
		note_sum = {1'b0, base_q} + (NOTE_W + 1)'(row_idx);
		note_ok  = !note_sum[NOTE_W];
		room     = cnt_q < CNT_W'(MAX_RESULTS);
		// Note-ons arrive in ascending order, so a word fills up before the next starts.
		if (acc_any_q && (acc_word_q == note_sum[NOTE_W-1:SND_BW])) begin
			acc_new = acc_q | (SND_BITS'(1) << note_sum[SND_BW-1:0]);
		end else begin
			acc_new = SND_BITS'(1) << note_sum[SND_BW-1:0];
		end
	end

	gsns_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	gsns_grid #(
		.ROWS    (ROWS),
		.COLUMNS (COLUMNS)
	) u_grid (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (grid_wr),
		.rd_en   (grid_re),
		.rd_col  (column_q),
		.rd_data (grid_rdata)
	);

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept && !action && playing_q) state_d = ST_DIV_OLD;
			end
			ST_DIV_OLD: begin
				if (div_rsp.done) state_d = ST_DIV_NEW;
			end
			ST_DIV_NEW: begin
				if (div_rsp.done) begin
					state_d = (div_rsp.quot == oldq_q) ? ST_IDLE : ST_DIV_MOD;
				end
			end
			ST_DIV_MOD: begin
				if (div_rsp.done) state_d = ST_OFF_RD;
			end
			ST_OFF_RD: state_d = ST_OFF_LD;
			ST_OFF_LD: state_d = ST_OFF_EMIT;
			ST_OFF_EMIT: begin
				if (bits_q == '0) begin
					state_d = (word_q == SND_AW'(SND_WORDS - 1)) ? ST_ON_RD : ST_OFF_RD;
				end
			end
			ST_ON_RD: state_d = ST_ON_LD;
			ST_ON_LD: state_d = ST_ON_EMIT;
			ST_ON_EMIT: begin
				if ((rowbits_q == '0) || !note_ok || !room) state_d = ST_FLUSH;
			end
			ST_FLUSH: state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// Control outputs
	always_comb begin
		div_req.start = 1'b0;
		div_req.num   = fc_q;
		div_req.den   = fps_eff;
		grid_wr.en    = 1'b0;
		grid_wr.col   = cell_column;
		grid_wr.row   = cell_row;
		grid_wr.on    = cell_on;
		grid_re       = 1'b0;
		snd_re        = 1'b0;
		snd_we        = 1'b0;
		snd_waddr     = word_q;
		snd_wdata     = '0;
		emit          = 1'b0;
		emit_ev.on    = 1'b0;
		emit_ev.note  = {word_q, off_bit};
		fire          = 1'b0;
		fire_last     = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (accept && action) begin
					grid_wr.en = 1'b1;
				end else if (accept && playing_q) begin
					// Step number before the add
					div_req.start = 1'b1;
				end
			end
			ST_DIV_OLD: begin
				// Step number after the add; fc_q already holds the new count
				div_req.start = div_rsp.done;
			end
			ST_DIV_NEW: begin
				if (div_rsp.done && (div_rsp.quot != oldq_q)) begin
					div_req.start = 1'b1;
					div_req.num   = div_rsp.quot;
					div_req.den   = FPS_W'(len_eff);
				end
			end
			ST_OFF_RD: snd_re = 1'b1;
			ST_OFF_LD: begin
				// Clear the word; its flags are held in bits_q for the note-offs
				snd_we = 1'b1;
			end
			ST_OFF_EMIT: begin
				emit = (bits_q != '0) && room;
			end
			ST_ON_RD: grid_re = 1'b1;
			ST_ON_EMIT: begin
				if ((rowbits_q != '0) && note_ok && room) begin
					emit         = 1'b1;
					emit_ev.on   = 1'b1;
					emit_ev.note = note_sum[NOTE_W-1:0];
					snd_we       = 1'b1;
					snd_waddr    = note_sum[NOTE_W-1:SND_BW];
					snd_wdata    = acc_new;
				end
			end
			ST_FLUSH: begin
				fire      = pend_v_q;
				fire_last = 1'b1;
			end
			default: ;
		endcase
		// Each new event pushes the previous one out; only the flush knows it is the last.
		if (emit) fire = pend_v_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fps_q     <= FPS_RESET;
			seq_len_q <= LEN_RESET;
			base_q    <= BASE_RESET;
			playing_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_FRAMES_PER_STEP: fps_q     <= cfg_data;
				REG_SEQUENCE_LENGTH: seq_len_q <= cfg_data[LEN_W-1:0];
				REG_BASE_NOTE:       base_q    <= cfg_data[NOTE_W-1:0];
				REG_PLAYING:         playing_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			fc_q       <= '0;
			column_q   <= '0;
			word_q     <= '0;
			cnt_q      <= '0;
			pend_v_q   <= 1'b0;
			acc_any_q  <= 1'b0;
			result_strobe_q <= 1'b0;
		end else begin
			state_q         <= state_d;
			result_strobe_q <= fire;
			if (accept && !action && playing_q) begin
				fc_q <= fc_q + FC_W'(sample_count);
			end
			if ((state_q == ST_DIV_MOD) && div_rsp.done) begin
				column_q <= div_rsp.rem[AW-1:0];
				word_q   <= '0;
				cnt_q    <= '0;
				pend_v_q <= 1'b0;
			end
			if ((state_q == ST_OFF_EMIT) && (bits_q == '0)) begin
				word_q <= word_q + 1'b1;
			end
			if (state_q == ST_ON_RD) begin
				acc_any_q <= 1'b0;
			end
			if (emit) begin
				cnt_q    <= cnt_q + 1'b1;
				pend_v_q <= 1'b1;
			end
			if ((state_q == ST_ON_EMIT) && emit) begin
				acc_any_q <= 1'b1;
			end
			if (state_q == ST_FLUSH) begin
				pend_v_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			frame_q <= frame_stamp;
		end
		if ((state_q == ST_DIV_OLD) && div_rsp.done) begin
			oldq_q <= div_rsp.quot;
		end
		if (state_q == ST_OFF_LD) begin
			bits_q <= snd_rdata;
		end else if ((state_q == ST_OFF_EMIT) && (bits_q != '0)) begin
			// Drop the lowest flag, emitted or not
			bits_q <= bits_q & (bits_q - 1'b1);
		end
		if (state_q == ST_ON_LD) begin
			rowbits_q <= grid_rdata;
		end else if ((state_q == ST_ON_EMIT) && emit) begin
			rowbits_q <= rowbits_q & (rowbits_q - 1'b1);
		end
		if ((state_q == ST_ON_EMIT) && emit) begin
			acc_q      <= acc_new;
			acc_word_q <= note_sum[NOTE_W-1:SND_BW];
		end
		if (emit) begin
			pend_q <= emit_ev;
		end
		if (fire) begin
			note_on_q     <= pend_q.on;
			note_q        <= pend_q.note;
			velocity_q    <= pend_q.on ? VEL_ON : VEL_OFF;
			event_frame_q <= frame_q;
			step_column_q <= STEP_W'(column_q);
			last_q        <= fire_last;
		end
	end

	// Sounding memory: a word never written reads as all notes silent.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			snd_vld_q <= '0;
		end else if (snd_we) begin
			snd_vld_q[snd_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (snd_we) begin
			snd_mem_q[snd_waddr] <= snd_wdata;
		end
		if (snd_re) begin
			snd_rword_q <= snd_mem_q[word_q];
			snd_rvld_q  <= snd_vld_q[word_q];
		end
	end

	assign snd_rdata = snd_rvld_q ? snd_rword_q : '0;

	assign result_strobe = result_strobe_q;
	assign note_on       = note_on_q;
	assign note          = note_q;
	assign velocity      = velocity_q;
	assign event_frame   = event_frame_q;
	assign step_column   = step_column_q;
	assign last          = last_q;

`ifndef NO_ASSERTIONS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(MAX_RESULTS))
		else $error("event count beyond the per-tick limit");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe_q |-> $past(state_q == ST_OFF_EMIT || state_q == ST_ON_EMIT ||
			state_q == ST_FLUSH))
		else $error("result shown outside the emit states");

	a_last_ends_tick: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe_q && last_q) |-> (state_q == ST_IDLE) && !pend_v_q)
		else $error("last result while the tick is still at work");

	a_snd_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(snd_we && snd_re))
		else $error("sounding memory read and written in one cycle");
`endif

endmodule

// ----- verif/gsns_tb_pkg.sv -----
`timescale 1ns / 1ps
// Testbench-side codes for the grid step note sequencer: command action values.
// Shared by the event checker and the test top; depends on nothing.
package gsns_tb_pkg;

	localparam logic ACT_TICK = 1'b0;
	localparam logic ACT_CELL = 1'b1;

endpackage

// ----- verif/gsns_event_checker.sv -----
`timescale 1ns / 1ps
// Event checker for the grid step note sequencer: tracks the command and config transfers,
// predicts the note events and compares them. Depends on gsns_pkg and gsns_tb_pkg.
module gsns_event_checker import gsns_pkg::*, gsns_tb_pkg::*; #(
	parameter int ROWS    = 16,
	parameter int COLUMNS = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  logic                 action,
	input  logic [SAMPLE_W-1:0]  sample_count,
	input  logic [FRAME_W-1:0]   frame_stamp,
	input  logic [CELL_W-1:0]    cell_column,
	input  logic [CELL_W-1:0]    cell_row,
	input  logic                 cell_on,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [FPS_W-1:0]     cfg_data,
	input  logic                 result_strobe,
	input  logic                 note_on,
	input  logic [NOTE_W-1:0]    note,
	input  logic [NOTE_W-1:0]    velocity,
	input  logic [FRAME_W-1:0]   event_frame,
	input  logic [STEP_W-1:0]    step_column,
	input  logic                 last,
	output int                   mismatches,
	output int                   outstanding
);

	typedef struct packed {
		logic               on;
		logic [NOTE_W-1:0]  pitch;
		logic [NOTE_W-1:0]  vel;
		logic [FRAME_W-1:0] frame;
		logic [STEP_W-1:0]  column;
		logic               final_one;
	} note_event_t;

	logic [FPS_W-1:0]  frames_per_step_q;
	logic [LEN_W-1:0]  seq_len_q;
	logic [NOTE_W-1:0] base_q;
	logic              playing_q;
	logic [FC_W-1:0]   frame_total;
	logic [STEP_W-1:0] column_cur;
	logic [ROWS-1:0]   cells [COLUMNS];
	logic [NOTES-1:0]  sounding_notes;
	note_event_t       due_events [$];
	int                fail_total = 0;

	task automatic flag_mismatch(input string what);
		if (fail_total < 100)
			$display("%0t ns: event mismatch: %s", $time, what);
		fail_total++;
	endtask

	function automatic note_event_t make_event(input logic on, input logic [NOTE_W-1:0] pitch,
			input logic [FRAME_W-1:0] stamp);
		note_event_t ev;
		ev.on        = on;
		ev.pitch     = pitch;
		ev.vel       = on ? VEL_ON : VEL_OFF;
		ev.frame     = stamp;
		ev.column    = column_cur;
		ev.final_one = 1'b0;
		return ev;
	endfunction

	// A tick while playing: move the frame counter, and on a new step silence everything and sound the column.
	task automatic advance_sequence(input logic [SAMPLE_W-1:0] frames,
			input logic [FRAME_W-1:0] stamp);
		logic [FC_W-1:0]   per_step;
		logic [FC_W-1:0]   loop_len;
		logic [FC_W-1:0]   step_before;
		logic [FC_W-1:0]   step_after;
		logic [NOTE_W:0]   pitch;
		note_event_t       ev;
		int                made;
		made = 0;
		if (!playing_q)
			return;
		per_step = (frames_per_step_q == '0) ? FC_W'(1) : FC_W'(frames_per_step_q);
		loop_len = (seq_len_q == '0) ? FC_W'(1) : FC_W'(seq_len_q);
		if (loop_len > FC_W'(COLUMNS))
			loop_len = FC_W'(COLUMNS);
		step_before = frame_total / per_step;
		frame_total = frame_total + FC_W'(frames);
		step_after  = frame_total / per_step;
		if (step_after == step_before)
			return;
		column_cur = STEP_W'(step_after % loop_len);
		for (int n = 0; n < NOTES; n++) begin
			if (sounding_notes[n]) begin
				sounding_notes[n] = 1'b0;
				if (made < MAX_RESULTS) begin
					due_events.push_back(make_event(1'b0, NOTE_W'(n), stamp));
					made++;
				end
			end
		end
		for (int r = 0; r < ROWS; r++) begin
			if (cells[column_cur][r]) begin
				pitch = {1'b0, base_q} + (NOTE_W + 1)'(r);
				if (pitch >= NOTES)
					continue;
				if (made >= MAX_RESULTS)
					break;
				due_events.push_back(make_event(1'b1, pitch[NOTE_W-1:0], stamp));
				sounding_notes[pitch[NOTE_W-1:0]] = 1'b1;
				made++;
			end
		end
		if (made > 0) begin
			ev = due_events.pop_back();
			ev.final_one = 1'b1;
			due_events.push_back(ev);
		end
	endtask

	task automatic check_event();
		note_event_t want;
		if (due_events.size() == 0) begin
			flag_mismatch($sformatf("unexpected event on=%0b note=%0d", note_on, note));
			return;
		end
		want = due_events.pop_front();
		if (note_on !== want.on)
			flag_mismatch($sformatf("note_on %0b, expected %0b", note_on, want.on));
		if (note !== want.pitch)
			flag_mismatch($sformatf("note %0d, expected %0d", note, want.pitch));
		if (velocity !== want.vel)
			flag_mismatch($sformatf("velocity %0d, expected %0d", velocity, want.vel));
		if (event_frame !== want.frame)
			flag_mismatch($sformatf("event_frame %0h, expected %0h", event_frame, want.frame));
		if (step_column !== want.column)
			flag_mismatch($sformatf("step_column %0d, expected %0d", step_column, want.column));
		if (last !== want.final_one)
			flag_mismatch($sformatf("last %0b, expected %0b (note %0d)", last, want.final_one,
				want.pitch));
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_per_step_q = FPS_RESET;
			seq_len_q         = LEN_RESET;
			base_q            = BASE_RESET;
			playing_q         = 1'b0;
			frame_total       = '0;
			column_cur        = '0;
			sounding_notes    = '0;
			for (int c = 0; c < COLUMNS; c++)
				cells[c] = '0;
			due_events.delete();
		end else begin
			// Results belong to earlier ticks, so compare before predicting this edge's command.
			if (result_strobe)
				check_event();
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_FRAMES_PER_STEP: frames_per_step_q = cfg_data;
					REG_SEQUENCE_LENGTH: seq_len_q = cfg_data[LEN_W-1:0];
					REG_BASE_NOTE:       base_q = cfg_data[NOTE_W-1:0];
					REG_PLAYING:         playing_q = cfg_data[0];
					default: ;
				endcase
			end
			if (start && !busy) begin
				if (action == ACT_CELL) begin
					if (cell_column < COLUMNS && cell_row < ROWS)
						cells[cell_column][cell_row] = cell_on;
				end else begin
					advance_sequence(sample_count, frame_stamp);
				end
			end
		end
		outstanding <= due_events.size();
		mismatches  <= fail_total;
	end

endmodule

// ----- verif/grid_step_note_sequencer_test.sv -----
`timescale 1ns / 1ps
// Test top for the grid step note sequencer: drives commands and register writes, and gives
// the verdict. Depends on gsns_pkg, gsns_tb_pkg, gsns_event_checker and the sequencer RTL.
module grid_step_note_sequencer_test;
	import gsns_pkg::*;
	import gsns_tb_pkg::*;

	// Longest quiet stretch of a correct run is the post-phase hold-off or a step-changing
	// tick behind the longest sender gap; allow several times that.
	localparam int SETTLE_CYCLES = 300;
	localparam int STALL_LIMIT   = 4000;
	localparam int RANDOM_ITEMS  = 360;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 start = 1'b0;
	logic                 action = ACT_TICK;
	logic [SAMPLE_W-1:0]  sample_count = '0;
	logic [FRAME_W-1:0]   frame_stamp = '0;
	logic [CELL_W-1:0]    cell_column = '0;
	logic [CELL_W-1:0]    cell_row = '0;
	logic                 cell_on = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_FRAMES_PER_STEP;
	logic [FPS_W-1:0]     cfg_data = '0;
	logic                 busy;
	logic                 cfg_ready;
	logic                 result_strobe;
	logic                 note_on;
	logic [NOTE_W-1:0]    note;
	logic [NOTE_W-1:0]    velocity;
	logic [FRAME_W-1:0]   event_frame;
	logic [STEP_W-1:0]    step_column;
	logic                 last;
	int                   mismatches;
	int                   outstanding;
	int                   quiet_cycles = 0;
	logic                 steady = 1'b0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	grid_step_note_sequencer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.sample_count  (sample_count),
		.frame_stamp   (frame_stamp),
		.cell_column   (cell_column),
		.cell_row      (cell_row),
		.cell_on       (cell_on),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.note_on       (note_on),
		.note          (note),
		.velocity      (velocity),
		.event_frame   (event_frame),
		.step_column   (step_column),
		.last          (last)
	);

	gsns_event_checker event_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.start         (start),
		.busy          (busy),
		.action        (action),
		.sample_count  (sample_count),
		.frame_stamp   (frame_stamp),
		.cell_column   (cell_column),
		.cell_row      (cell_row),
		.cell_on       (cell_on),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_strobe (result_strobe),
		.note_on       (note_on),
		.note          (note),
		.velocity      (velocity),
		.event_frame   (event_frame),
		.step_column   (step_column),
		.last          (last),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	// Watchdog: count cycles with no transfer on any channel.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			quiet_cycles <= 0;
		else if ((start && !busy) || (cfg_valid && cfg_ready) || result_strobe)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		wait (quiet_cycles >= STALL_LIMIT);
		$display("FAILURE");
		$finish;
	end

	// Mostly short gaps, a few long ones that land deep inside a step-changing tick.
	function automatic int pick_gap();
		int roll;
		if (steady)
			return 0;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return 0;
		if (roll < 85)
			return $urandom_range(1, 3);
		if (roll < 97)
			return $urandom_range(4, 20);
		return $urandom_range(30, 300);
	endfunction

	// Hold start high until the transfer; leave it high so a back-to-back item needs no
	// second assignment in the same step.
	task automatic issue_item(input logic act, input logic [SAMPLE_W-1:0] frames,
			input logic [FRAME_W-1:0] stamp, input logic [CELL_W-1:0] col,
			input logic [CELL_W-1:0] row, input logic on);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start        <= 1'b1;
		action       <= act;
		sample_count <= frames;
		frame_stamp  <= stamp;
		cell_column  <= col;
		cell_row     <= row;
		cell_on      <= on;
		do @(posedge clk); while (busy);
	endtask

	// Unused fields carry random bits so every input bit toggles.
	task automatic send_tick(input logic [SAMPLE_W-1:0] frames, input logic [FRAME_W-1:0] stamp);
		issue_item(ACT_TICK, frames, stamp, CELL_W'($urandom()), CELL_W'($urandom()),
			1'($urandom()));
	endtask

	task automatic send_cell(input logic [CELL_W-1:0] col, input logic [CELL_W-1:0] row,
			input logic on);
		issue_item(ACT_CELL, SAMPLE_W'($urandom()), FRAME_W'($urandom()), col, row, on);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [FPS_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
	endtask

	// Narrow registers get random junk above their width; the block must drop it.
	task automatic load_setup(input logic [FPS_W-1:0] per_step, input logic [LEN_W-1:0] len,
			input logic [NOTE_W-1:0] base, input logic play);
		write_reg(REG_FRAMES_PER_STEP, per_step);
		write_reg(REG_SEQUENCE_LENGTH, FPS_W'({$urandom(), len}));
		write_reg(REG_BASE_NOTE, FPS_W'({$urandom(), base}));
		write_reg(REG_PLAYING, FPS_W'({$urandom(), play}));
		cfg_valid <= 1'b0;
	endtask

	// Drop start, wait for every predicted event, then let a silent tick finish.
	task automatic settle();
		start <= 1'b0;
		do @(posedge clk); while (outstanding != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		int                sent;
		int                batch;
		int                roll;
		logic [FPS_W-1:0]  per_step;
		logic [LEN_W-1:0]  len;
		logic [NOTE_W-1:0] base;
		logic [CELL_W-1:0] col;
		logic              turn_on;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: defaults have playing off, so this tick must do nothing.
		send_tick(16'hFFFF, 16'hFFFF);
		send_cell(4'd0, 4'd0, 1'b1);
		send_cell(4'd0, 4'd15, 1'b1);
		send_cell(4'd15, 4'd15, 1'b1);
		send_cell(4'd3, 4'd7, 1'b1);
		send_cell(4'd3, 4'd7, 1'b0);
		send_cell(4'd1, 4'd5, 1'b1);
		settle();

		// Zero frames per step and zero length act as one; base 127 pushes row 15 off the top.
		load_setup('0, '0, 7'd127, 1'b1);
		send_tick(16'd1, 16'hFFFF);
		send_tick(16'd0, 16'h1234);
		send_tick(16'hFFFF, 16'h0000);
		settle();

		// One frame per step and a length above the grid width, which saturates.
		load_setup(24'd1, 5'd31, 7'd0, 1'b1);
		send_tick(16'd1, 16'h00FF);
		send_tick(16'd13, 16'hFF00);
		send_tick(16'd1, 16'h5A5A);
		send_tick(16'd1, 16'hA5A5);
		settle();

		// Largest step size: a full tick cannot reach the next step.
		load_setup(24'hFFFFFF, 5'd1, 7'd60, 1'b1);
		send_tick(16'hFFFF, 16'h0F0F);
		settle();

		load_setup(FPS_RESET, LEN_RESET, BASE_RESET, 1'b0);
		send_tick(16'h8000, 16'hF0F0);
		settle();

		// Random phases: a fresh setting, then a batch of ticks and cell writes.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 99);
			if (roll < 10)
				per_step = '0;
			else if (roll < 20)
				per_step = 24'hFFFFFF;
			else if (roll < 30)
				per_step = 24'd1;
			else if (roll < 80)
				per_step = FPS_W'($urandom_range(100, 3000));
			else
				per_step = FPS_W'($urandom_range(3000, 70000));
			roll = $urandom_range(0, 99);
			if (roll < 70)
				len = LEN_W'($urandom_range(1, 16));
			else if (roll < 85)
				len = '0;
			else
				len = LEN_W'($urandom_range(17, 31));
			roll = $urandom_range(0, 99);
			if (roll < 70)
				base = NOTE_W'($urandom_range(40, 100));
			else if (roll < 85)
				base = '0;
			else
				base = NOTE_W'($urandom_range(113, 127));
			load_setup(per_step, len, base, $urandom_range(0, 9) != 0);
			steady = ($urandom_range(0, 3) == 0);
			batch  = $urandom_range(15, 40);
			repeat (batch) begin
				roll = $urandom_range(0, 99);
				if (roll < 60) begin
					if ($urandom_range(0, 4) == 0)
						send_tick(SAMPLE_W'($urandom_range(0, 15)), FRAME_W'($urandom()));
					else if ($urandom_range(0, 19) == 0)
						send_tick(16'hFFFF, FRAME_W'($urandom()));
					else
						send_tick(SAMPLE_W'($urandom()), FRAME_W'($urandom()));
					sent++;
				end else if (roll < 90) begin
					send_cell(CELL_W'($urandom()), CELL_W'($urandom()),
						$urandom_range(0, 4) < 3);
					sent++;
				end else begin
					// Fill or clear a whole column to reach the busiest steps.
					col     = CELL_W'($urandom());
					turn_on = $urandom_range(0, 3) != 0;
					for (int r = 0; r < 16; r++)
						send_cell(col, CELL_W'(r), turn_on);
					sent += 16;
				end
			end
			steady = 1'b0;
			settle();
		end

		if (mismatches == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
